// ----- sv/htd_pkg.sv -----
package htd_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned CODE_IW = $clog2(CODE_W);
  localparam int unsigned LEN_W   = 6;

  // item commands; the fourth code leaves the tree alone and returns an empty result
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

endpackage

// ----- sv/huffman_tree_build_and_decode.sv -----
// steps, transfer in to result out: decode reads the node under the position (S_DC_READ),
//   then the child if one exists (S_DC_NEXT); load takes S_LD_STEP per code bit and for the store, with
//   an S_LD_FETCH for each existing node; every command ends in S_OUT, which waits for the output register
// throughput: one item at a time; the next input transfer is taken only once the result
//   has entered the output register and the block is back in idle
// reset: asynchronous, active low; empty tree (root in flops), one node used, root position
module huffman_tree_build_and_decode #(
  parameter int unsigned NODE_COUNT   = 512,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [htd_pkg::CMD_W-1:0]     cmd_i,
  input  logic [htd_pkg::SYM_W-1:0]     symbol_in_i,
  input  logic [htd_pkg::CODE_W-1:0]    code_bits_i,
  input  logic [htd_pkg::LEN_W-1:0]     code_length_i,
  input  logic                          bit_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          symbol_valid_o,
  output logic [htd_pkg::SYM_W-1:0]     symbol_out_o,
  output logic                          overflow_o
);

  // node index width and node counter width (counter can hold NODE_COUNT itself)
  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned UW = $clog2(NODE_COUNT + 1);
  // walk length counter, saturated at MAX_CODE_LEN
  localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);

  // one node word: both child links and the symbol; link zero means no child
  typedef struct packed {
    logic [NW-1:0]               left;
    logic [NW-1:0]               right;
    logic [htd_pkg::SYM_W-1:0]   sym;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_STEP,
    S_LD_FETCH,
    S_DC_READ,
    S_DC_NEXT,
    S_OUT
  } state_e;

  // node memory; entry 0 is unused, the root lives in flops so reset and clear are instant
  node_t mem_q [NODE_COUNT];
  node_t rd_q;

  logic              mem_we;
  logic [NW-1:0]     mem_waddr;
  node_t             mem_wdata;
  logic              mem_re;
  logic [NW-1:0]     mem_raddr;

  state_e            state_q, state_d;
  node_t             root_q, root_d;
  logic [UW-1:0]     used_q, used_d;
  logic [NW-1:0]     cur_q, cur_d;

  // load walk context
  logic [NW-1:0]               node_idx_q, node_idx_d;
  node_t                       node_q, node_d;
  logic [LW-1:0]               len_q, len_d;
  logic [htd_pkg::CODE_W-1:0]  bits_q, bits_d;
  logic [htd_pkg::SYM_W-1:0]   sym_q, sym_d;

  // decode context
  logic              bit_q, bit_d;
  logic [NW-1:0]     dnode_q, dnode_d;

  // finished result, then the output register
  logic                        res_valid_q, res_valid_d;
  logic [htd_pkg::SYM_W-1:0]   res_sym_q, res_sym_d;
  logic                        res_ovf_q, res_ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_sym_valid_q, out_sym_valid_d;
  logic [htd_pkg::SYM_W-1:0]   out_sym_q, out_sym_d;
  logic                        out_ovf_q, out_ovf_d;

  // node write request, steered to root flops or memory
  logic              wr_en;
  logic [NW-1:0]     wr_idx;
  node_t             wr_word;

  logic [LW-1:0]     pos;
  logic [31:0]       pos_w;
  logic              code_bit;
  logic [NW-1:0]     walk_next;
  node_t             dec_word;
  logic [NW-1:0]     dec_next;
  logic [LW-1:0]     len_sat;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign symbol_valid_o = out_sym_valid_q;
  assign symbol_out_o   = out_sym_q;
  assign overflow_o     = out_ovf_q;

  // code bit at position len-1; positions past the 32-bit field read as zero
  assign pos       = len_q - LW'(1);
  assign pos_w     = 32'(pos);
  assign code_bit  = (pos_w < 32'(htd_pkg::CODE_W)) ? bits_q[pos_w[htd_pkg::CODE_IW-1:0]] : 1'b0;
  assign walk_next = code_bit ? node_q.right : node_q.left;

  // node under the decode position: root from flops, else the memory read data
  assign dec_word = (cur_q == '0) ? root_q : rd_q;
  assign dec_next = bit_q ? dec_word.right : dec_word.left;

  // over-long codes saturate
  assign len_sat = (32'(code_length_i) > 32'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                            : LW'(code_length_i);

  always_comb begin
    state_d         = state_q;
    root_d          = root_q;
    used_d          = used_q;
    cur_d           = cur_q;
    node_idx_d      = node_idx_q;
    node_d          = node_q;
    len_d           = len_q;
    bits_d          = bits_q;
    sym_d           = sym_q;
    bit_d           = bit_q;
    dnode_d         = dnode_q;
    res_valid_d     = res_valid_q;
    res_sym_d       = res_sym_q;
    res_ovf_d       = res_ovf_q;
    out_valid_d     = out_valid_q;
    out_sym_valid_d = out_sym_valid_q;
    out_sym_d       = out_sym_q;
    out_ovf_d       = out_ovf_q;
    wr_en           = 1'b0;
    wr_idx          = '0;
    wr_word         = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_valid_d = 1'b0;
          res_sym_d   = '0;
          res_ovf_d   = 1'b0;
          case (htd_pkg::cmd_e'(cmd_i))
            htd_pkg::CMD_LOAD: begin
              node_idx_d = '0;
              node_d     = root_q;
              len_d      = len_sat;
              bits_d     = code_bits_i;
              sym_d      = symbol_in_i;
              state_d    = S_LD_STEP;
            end
            htd_pkg::CMD_DECODE: begin
              bit_d     = bit_in_i;
              mem_re    = 1'b1;
              mem_raddr = cur_q;
              state_d   = S_DC_READ;
            end
            htd_pkg::CMD_CLEAR: begin
              root_d  = '0;
              used_d  = UW'(1);
              cur_d   = '0;
              state_d = S_OUT;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      // one code bit per visit: follow or make a child; store the symbol at the end or stop when full
      S_LD_STEP: begin
        if (len_q == '0) begin
          // end of code: store the symbol, keep any children
          wr_en       = 1'b1;
          wr_idx      = node_idx_q;
          wr_word     = node_q;
          wr_word.sym = sym_q;
          state_d     = S_OUT;
        end else if (walk_next != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = walk_next;
          node_idx_d = walk_next;
          len_d      = len_q - LW'(1);
          state_d    = S_LD_FETCH;
        end else if (used_q == UW'(NODE_COUNT)) begin
          // store full: write back the walk node so a fresh node is in memory
          wr_en     = 1'b1;
          wr_idx    = node_idx_q;
          wr_word   = node_q;
          res_ovf_d = 1'b1;
          state_d   = S_OUT;
        end else begin
          // link the parent to the new node; new node stays in node_q until written
          wr_en   = 1'b1;
          wr_idx  = node_idx_q;
          wr_word = node_q;
          if (code_bit) begin
            wr_word.right = used_q[NW-1:0];
          end else begin
            wr_word.left = used_q[NW-1:0];
          end
          node_idx_d = used_q[NW-1:0];
          node_d     = '0;
          used_d     = used_q + UW'(1);
          len_d      = len_q - LW'(1);
        end
      end

      S_LD_FETCH: begin
        node_d  = rd_q;
        state_d = S_LD_STEP;
      end

      S_DC_READ: begin
        if (dec_next != '0) begin
          mem_re    = 1'b1;
          mem_raddr = dec_next;
          dnode_d   = dec_next;
          state_d   = S_DC_NEXT;
        end else begin
          // missing child: position stays, leaf test on the same node
          if (dec_word.left == '0 && dec_word.right == '0) begin
            res_valid_d = 1'b1;
            res_sym_d   = dec_word.sym;
            cur_d       = '0;
          end
          state_d = S_OUT;
        end
      end

      S_DC_NEXT: begin
        if (rd_q.left == '0 && rd_q.right == '0) begin
          res_valid_d = 1'b1;
          res_sym_d   = rd_q.sym;
          cur_d       = '0;
        end else begin
          cur_d = dnode_q;
        end
        state_d = S_OUT;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_sym_valid_d = res_valid_q;
          out_sym_d       = res_sym_q;
          out_ovf_d       = res_ovf_q;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // root writes go to flops, all others to memory
    if (wr_en && (wr_idx == '0)) begin
      root_d = wr_word;
    end
  end

  assign mem_we    = wr_en && (wr_idx != '0);
  assign mem_waddr = wr_idx;
  assign mem_wdata = wr_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      root_q          <= '0;
      used_q          <= UW'(1);
      cur_q           <= '0;
      node_idx_q      <= '0;
      node_q          <= '0;
      len_q           <= '0;
      bits_q          <= '0;
      sym_q           <= '0;
      bit_q           <= 1'b0;
      dnode_q         <= '0;
      res_valid_q     <= 1'b0;
      res_sym_q       <= '0;
      res_ovf_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      out_sym_valid_q <= 1'b0;
      out_sym_q       <= '0;
      out_ovf_q       <= 1'b0;
    end else begin
      state_q         <= state_d;
      root_q          <= root_d;
      used_q          <= used_d;
      cur_q           <= cur_d;
      node_idx_q      <= node_idx_d;
      node_q          <= node_d;
      len_q           <= len_d;
      bits_q          <= bits_d;
      sym_q           <= sym_d;
      bit_q           <= bit_d;
      dnode_q         <= dnode_d;
      res_valid_q     <= res_valid_d;
      res_sym_q       <= res_sym_d;
      res_ovf_q       <= res_ovf_d;
      out_valid_q     <= out_valid_d;
      out_sym_valid_q <= out_sym_valid_d;
      out_sym_q       <= out_sym_d;
      out_ovf_q       <= out_ovf_d;
    end
  end

  // node memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

endmodule

// ----- sim/tb.sv -----
module tb;

  localparam int unsigned NODES    = 512;
  localparam int unsigned LEN_CAP  = 32;
  localparam int unsigned ITEM_GOAL = 2000;
  localparam int unsigned CALM_FROM = 1700;

  typedef logic [htd_pkg::CMD_W-1:0]  cmd_t;
  typedef logic [htd_pkg::SYM_W-1:0]  sym_t;
  typedef logic [htd_pkg::CODE_W-1:0] code_t;
  typedef logic [htd_pkg::LEN_W-1:0]  len_t;

  // the block leaves the tree alone for this command code and returns an empty result
  localparam cmd_t CMD_SPARE = 2'd3;

  // what one result transfer carries
  typedef struct packed {
    logic hit;
    sym_t sym;
    logic ovf;
  } tree_result_t;

  // own copy of the code tree, fed with every input transfer, and the queue
  // of results it expects back from the block
  class code_tree_checker;
    logic [8:0]       left_q  [NODES];
    logic [8:0]       right_q [NODES];
    sym_t             sym_q   [NODES];
    int unsigned      used;
    logic [8:0]       pos;
    tree_result_t     expected_results[$];
    int unsigned      errors;
    int unsigned      seen;

    function new();
      empty_tree();
      errors = 0;
      seen   = 0;
    endfunction

    function void empty_tree();
      left_q[0]  = '0;
      right_q[0] = '0;
      sym_q[0]   = '0;
      used       = 1;
      pos        = '0;
    endfunction

    // walk the code from the root, making missing nodes; 1 when the store ran dry
    function logic walk_code(sym_t s, code_t code, len_t len);
      int unsigned depth;
      logic [8:0]  node;
      logic [8:0]  nxt;
      logic        b;
      depth = (len > LEN_CAP) ? LEN_CAP : len;
      node  = '0;
      for (int i = depth; i > 0; i--) begin
        b   = code[i-1];
        nxt = b ? right_q[node] : left_q[node];
        if (nxt == 0) begin
          if (used >= NODES) return 1'b1;
          nxt          = used[8:0];
          left_q[nxt]  = '0;
          right_q[nxt] = '0;
          sym_q[nxt]   = '0;
          used++;
          if (b) right_q[node] = nxt;
          else left_q[node] = nxt;
        end
        node = nxt;
      end
      sym_q[node] = s;
      return 1'b0;
    endfunction

    function void take_item(cmd_t cmd, sym_t s, code_t code, len_t len, logic b);
      tree_result_t r;
      logic [8:0]   nxt;
      r = '0;
      case (cmd)
        htd_pkg::CMD_LOAD: r.ovf = walk_code(s, code, len);
        htd_pkg::CMD_DECODE: begin
          nxt = b ? right_q[pos] : left_q[pos];
          // missing child: stay put, but the leaf test still applies
          if (nxt != 0) pos = nxt;
          if (left_q[pos] == 0 && right_q[pos] == 0) begin
            r.hit = 1'b1;
            r.sym = sym_q[pos];
            pos   = '0;
          end
        end
        htd_pkg::CMD_CLEAR: empty_tree();
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void match_output(logic hit, sym_t s, logic ovf);
      tree_result_t want;
      seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with nothing outstanding: v=%0b s=%02h o=%0b",
                   seen, hit, s, ovf);
        return;
      end
      want = expected_results.pop_front();
      if (hit !== want.hit || s !== want.sym || ovf !== want.ovf) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: want v=%0b s=%02h o=%0b, got v=%0b s=%02h o=%0b",
                   seen, want.hit, want.sym, want.ovf, hit, s, ovf);
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void close_out();
      if (expected_results.size() != 0) begin
        errors += expected_results.size();
        $display("%0d results never arrived", expected_results.size());
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic [htd_pkg::CMD_W-1:0]   cmd_i         = '0;
  logic [htd_pkg::SYM_W-1:0]   symbol_in_i   = '0;
  logic [htd_pkg::CODE_W-1:0]  code_bits_i   = '0;
  logic [htd_pkg::LEN_W-1:0]   code_length_i = '0;
  logic                        bit_in_i      = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic                        symbol_valid_o;
  logic [htd_pkg::SYM_W-1:0]   symbol_out_o;
  logic                        overflow_o;

  code_tree_checker tree_sb = new();

  int unsigned items_sent = 0;
  bit          idle_on    = 1'b1;   // random idle bursts on both sides
  bit          hold_req   = 1'b0;   // asks the receiver for one long hold-off

  huffman_tree_build_and_decode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .symbol_in_i   (symbol_in_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .bit_in_i      (bit_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_valid_o(symbol_valid_o),
    .symbol_out_o  (symbol_out_o),
    .overflow_o    (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // offer one item and wait for its transfer; called and returns at a rising edge
  task automatic send_item(cmd_t cmd, sym_t s, code_t code, len_t len, logic b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    symbol_in_i   <= s;
    code_bits_i   <= code;
    code_length_i <= len;
    bit_in_i      <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tree_sb.take_item(cmd, s, code, len, b);
    items_sent++;
  endtask

  task automatic load_code(sym_t s, code_t code, len_t len);
    send_item(htd_pkg::CMD_LOAD, s, code, len, 1'($urandom_range(0, 1)));
  endtask

  task automatic decode_bit(logic b);
    send_item(htd_pkg::CMD_DECODE, sym_t'($urandom), code_t'($urandom), len_t'($urandom), b);
  endtask

  task automatic clear_tree();
    send_item(htd_pkg::CMD_CLEAR, sym_t'($urandom), code_t'($urandom), len_t'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  // sender pause: stop offering until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tree_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // well-formed round: fresh tree from a random complete prefix code set,
  // then a message made of those codes, msb first
  task automatic code_round();
    code_t       cb[$];
    int unsigned cl[$];
    int unsigned leaves;
    int unsigned idx;
    int unsigned msg_len;
    code_t       b0;
    int unsigned l0;
    cb.push_back('0);
    cl.push_back(0);
    leaves = $urandom_range(2, 12);
    while (cb.size() < leaves) begin
      idx = $urandom_range(0, cb.size() - 1);
      if (cl[idx] < 10) begin
        b0      = cb[idx];
        l0      = cl[idx];
        cb[idx] = b0 << 1;
        cl[idx] = l0 + 1;
        cb.push_back((b0 << 1) | 1);
        cl.push_back(l0 + 1);
      end
    end
    clear_tree();
    foreach (cb[j]) load_code(sym_t'($urandom), cb[j], len_t'(cl[j]));
    msg_len = $urandom_range(4, 16);
    repeat (msg_len) begin
      idx = $urandom_range(0, cb.size() - 1);
      for (int k = cl[idx] - 1; k >= 0; k--) decode_bit(cb[idx][k]);
    end
  endtask

  // long random codes until the node store runs out, then a few bits
  task automatic fill_round();
    clear_tree();
    repeat (18) load_code(sym_t'($urandom), code_t'($urandom), 6'd32);
    repeat (12) decode_bit(1'($urandom_range(0, 1)));
  endtask

  // anything goes, stray command code too
  task automatic noise_round();
    len_t len;
    repeat (10) begin
      if ($urandom_range(0, 3) != 0) len = len_t'($urandom_range(0, 8));
      else len = len_t'($urandom_range(0, 63));
      send_item(cmd_t'($urandom_range(0, 3)), sym_t'($urandom), code_t'($urandom), len,
                1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: checks each result transfer, then picks ready for the next cycle
  initial begin : result_side
    int unsigned hold_cnt;
    int unsigned burst;
    hold_cnt = 0;
    burst    = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        tree_sb.match_output(symbol_valid_o, symbol_out_o, overflow_o);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        // long hold-off so the block backs up into its input
        hold_req    = 1'b0;
        hold_cnt    = 300;
        out_ready_i <= 1'b0;
      end else begin
        if (idle_on && burst == 0 && $urandom_range(0, 4) == 0)
          burst = $urandom_range(1, 5);
        if (!idle_on) burst = 0;
        if (burst > 0) begin
          burst--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin : item_side
    int unsigned kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty root has no children, so a decode gives its zero symbol
    decode_bit(1'b0);
    // empty code writes into the root, which then decodes on any bit
    load_code(8'hA5, '0, 6'd0);
    decode_bit(1'b1);
    load_code(8'h11, 32'h0, 6'd1);
    load_code(8'h22, 32'h2, 6'd2);
    load_code(8'h33, 32'h3, 6'd2);
    decode_bit(1'b1);
    decode_bit(1'b0);
    decode_bit(1'b0);
    // existing leaf overwritten
    load_code(8'hFF, 32'h3, 6'd2);
    decode_bit(1'b1);
    decode_bit(1'b1);
    // code ending on an inner node keeps its children
    load_code(8'h44, 32'h1, 6'd1);
    // one-sided branch under the left leaf, then a bit with no child
    load_code(8'h00, 32'h0, 6'd3);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    decode_bit(1'b0);
    // over-long lengths saturate at the cap
    load_code(8'h66, 32'hFFFF_FFFF, 6'd63);
    load_code(8'h77, 32'h8000_0001, 6'd33);
    load_code(8'h88, 32'h8000_0000, 6'd32);
    send_item(CMD_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    clear_tree();
    decode_bit(1'b1);

    // receiver backs off for a long stretch while the store fills up
    hold_req = 1'b1;
    fill_round();
    drain();
    @(posedge clk_i);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= CALM_FROM) idle_on = 1'b0;
      kind = $urandom_range(0, 9);
      if (kind <= 5) code_round();
      else if (kind == 6) fill_round();
      else noise_round();
      if (kind == 0 && $urandom_range(0, 3) == 0) begin
        drain();
        @(posedge clk_i);
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    tree_sb.close_out();
    if (tree_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- huffman_tree_build_and_decode.f -----
sv/htd_pkg.sv
sv/huffman_tree_build_and_decode.sv
sim/tb.sv
